// ----- rtl/apc_pkg.sv -----
// ----------------------------------------------------------------------------
// apc_pkg: shared types, constants and helpers of the anaglyph pixel combiner
// Luma weights in Q8, channel limits, mode codes and stage control groups.
// ----------------------------------------------------------------------------
`default_nettype none

package apc_pkg;

    // Luma weights: 0.21 / 0.72 / 0.07 in Q8
    localparam logic [7:0] LUMA_KR = 8'd54;
    localparam logic [7:0] LUMA_KG = 8'd184;
    localparam logic [7:0] LUMA_KB = 8'd18;

    // Largest value of one color channel
    localparam logic [7:0] CH_MAX = 8'd255;

    // Widths of the luma path (max sum is 65280)
    localparam int PIX_W  = 24;
    localparam int LUMA_W = 16;
    localparam int PR_W   = 14;   // 54 * 255
    localparam int PG_W   = 16;   // 184 * 255
    localparam int PB_W   = 13;   // 18 * 255

    typedef enum logic {
        MODE_ANAGLYPH = 1'b0,
        MODE_GRAY     = 1'b1
    } t_mode;

    // Load enables of the two luma stages
    typedef struct packed {
        logic ld_prod;
        logic ld_sum;
    } t_lum_ctl;

    // Clamp a 9-bit value to one channel
    function automatic logic [7:0] sat8(input logic [8:0] v);
        logic [7:0] res;
        res = v[8] ? CH_MAX : v[7:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/anaglyph_pixel_combiner.sv -----
// ----------------------------------------------------------------------------
// anaglyph_pixel_combiner: red-blue anaglyph or grayscale of a pixel pair
// Three-stage pipeline: weighted channels, luma sums, channel mix.
// ----------------------------------------------------------------------------
// An accepted input beat passes the product, sum and mix registers in turn to its output.
// Throughput: one beat per cycle; each stage moves on when the next one
// is empty or moving, so a stalled sink freezes only the unbroken run of
// full stages at the output; stages behind the first empty one keep moving.
// Reset: synchronous, active low; clears the stage valid bits only.
`default_nettype none

module anaglyph_pixel_combiner
    import apc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_mode,
    input  wire logic [PIX_W-1:0] i_left_pixel,
    input  wire logic [PIX_W-1:0] i_right_pixel,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic      [PIX_W-1:0] o_out_pixel
);

    logic  r_v1;
    logic  r_v2;
    logic  r_v3;
    t_mode r_mode1;
    t_mode r_mode2;

    logic     rdy1;
    logic     rdy2;
    logic     rdy3;
    t_lum_ctl lum_ctl;

    logic [LUMA_W-1:0] luma_l;
    logic [LUMA_W-1:0] luma_r;

    // A stage takes a beat when it is empty or its beat moves on
    always_comb begin
        rdy3            = !r_v3 || i_ready;
        rdy2            = !r_v2 || rdy3;
        rdy1            = !r_v1 || rdy2;
        lum_ctl.ld_prod = rdy1;
        lum_ctl.ld_sum  = rdy2;
    end

    assign o_ready = rdy1;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Carry the mode along with the data
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_mode1 <= t_mode'(i_mode);
        end
        if (rdy2) begin
            r_mode2 <= r_mode1;
        end
    end

    apc_luma u_luma_l (
        .i_clk   (i_clk),
        .i_ctl   (lum_ctl),
        .i_pixel (i_left_pixel),
        .o_luma  (luma_l)
    );

    apc_luma u_luma_r (
        .i_clk   (i_clk),
        .i_ctl   (lum_ctl),
        .i_pixel (i_right_pixel),
        .o_luma  (luma_r)
    );

    apc_mix u_mix (
        .i_clk    (i_clk),
        .i_ld     (rdy3),
        .i_mode   (r_mode2),
        .i_luma_l (luma_l),
        .i_luma_r (luma_r),
        .o_pixel  (o_out_pixel)
    );

    assign o_valid = r_v3;

endmodule

`default_nettype wire

// ----- rtl/apc_luma.sv -----
// ----------------------------------------------------------------------------
// apc_luma: two-stage Q8 luma of one 0xRRGGBB pixel
// Stage one registers the three weighted channels, stage two their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_luma
    import apc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_lum_ctl          i_ctl,
    input  wire logic [PIX_W-1:0]  i_pixel,
    output logic      [LUMA_W-1:0] o_luma
);

    logic [PR_W-1:0]   r_prod_r;
    logic [PG_W-1:0]   r_prod_g;
    logic [PB_W-1:0]   r_prod_b;
    logic [LUMA_W-1:0] r_luma;

    logic [15:0] n_prod_r;
    logic [15:0] n_prod_g;
    logic [15:0] n_prod_b;
    logic [LUMA_W-1:0] n_luma;

    // Weight each channel
    always_comb begin
        n_prod_r = 16'(LUMA_KR) * 16'(i_pixel[23:16]);
        n_prod_g = 16'(LUMA_KG) * 16'(i_pixel[15:8]);
        n_prod_b = 16'(LUMA_KB) * 16'(i_pixel[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_prod_r <= n_prod_r[PR_W-1:0];
            r_prod_g <= n_prod_g[PG_W-1:0];
            r_prod_b <= n_prod_b[PB_W-1:0];
        end
    end

    // Add the weighted channels
    assign n_luma = LUMA_W'(r_prod_r) + LUMA_W'(r_prod_g) + LUMA_W'(r_prod_b);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_luma <= n_luma;
        end
    end

    assign o_luma = r_luma;

endmodule

`default_nettype wire

// ----- rtl/apc_mix.sv -----
// ----------------------------------------------------------------------------
// apc_mix: channel mixing and output register
// Builds the saturated anaglyph pixel from both luma values, or the grayscale pixel from the left luma.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_mix
    import apc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_ld,
    input  wire t_mode             i_mode,
    input  wire logic [LUMA_W-1:0] i_luma_l,
    input  wire logic [LUMA_W-1:0] i_luma_r,
    output logic      [PIX_W-1:0]  o_pixel
);

    logic [PIX_W-1:0] r_pixel;
    logic [PIX_W-1:0] n_pixel;

    logic [7:0] l_dbl;
    logic [7:0] r_dbl;
    logic [6:0] l_half;
    logic [6:0] r_half;
    logic [7:0] ch_r;
    logic [7:0] ch_g;
    logic [7:0] ch_b;

    // Double luma feeds its own channel, half luma the others
    always_comb begin
        l_dbl  = sat8(i_luma_l[15:7]);
        r_dbl  = sat8(i_luma_r[15:7]);
        l_half = i_luma_l[15:9];
        r_half = i_luma_r[15:9];
        ch_r   = sat8(9'(l_dbl) + 9'(r_half));
        ch_g   = sat8(9'(l_half) + 9'(r_half));
        ch_b   = sat8(9'(l_half) + 9'(r_dbl));
        if (i_mode == MODE_GRAY) begin
            n_pixel = {i_luma_l[15:8], i_luma_l[15:8], i_luma_l[15:8]};
        end else begin
            n_pixel = {ch_r, ch_g, ch_b};
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

`default_nettype wire

// ----- rtl/apc_checker.sv -----
// ----------------------------------------------------------------------------
// apc_checker: port-level checks of the anaglyph pixel combiner
// Watches reset, stall behavior, pipeline latency and back pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_checker
    import apc_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_ready,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [PIX_W-1:0] o_out_pixel
);

    // Reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_pixel))
        else $error("stalled output beat changed");

    // Empty output stage never pushes back on the source
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // Accepted beat reaches the output when the sink stays open while it passes the stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind anaglyph_pixel_combiner apc_checker u_apc_checker (.*);

`default_nettype wire
